@@ rtl/core/pis_pkg.sv @@
// Shared widths, register indexes and a saturation helper for the PID
// controller with integral separation. No dependencies.
package pis_pkg;

	localparam int SAMPLE_WIDTH   = 16;
	localparam int GAIN_WIDTH     = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int LIMIT_WIDTH    = 16;
	localparam int ERR_WIDTH      = SAMPLE_WIDTH + 1;
	localparam int DERIV_WIDTH    = SAMPLE_WIDTH + 2;
	localparam int SUM_WIDTH      = 32;
	localparam int DRIVE_WIDTH    = 32;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = 16;

	localparam int P_KP_WIDTH = GAIN_WIDTH + ERR_WIDTH;
	localparam int P_KI_WIDTH = GAIN_WIDTH + SUM_WIDTH;
	localparam int P_KD_WIDTH = GAIN_WIDTH + DERIV_WIDTH;
	localparam int ACC_WIDTH  = P_KI_WIDTH + 2;

	localparam logic [LIMIT_WIDTH-1:0] SEP_RESET = LIMIT_WIDTH'(400);

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_KP  = 2'd0,
		REG_KI  = 2'd1,
		REG_KD  = 2'd2,
		REG_SEP = 2'd3
	} cfg_reg_t;

	// Clamp a sign-extended accumulator to the signed 32-bit range.
	function automatic logic signed [DRIVE_WIDTH-1:0] sat_drive(
		input logic signed [ACC_WIDTH-1:0] v
	);
		logic hi_ones;
		logic hi_zeros;
		logic signed [DRIVE_WIDTH-1:0] r;
		hi_ones  = &v[ACC_WIDTH-1:DRIVE_WIDTH-1];
		hi_zeros = ~|v[ACC_WIDTH-1:DRIVE_WIDTH-1];
		if (hi_ones || hi_zeros) begin
			r = v[DRIVE_WIDTH-1:0];
		end else if (v[ACC_WIDTH-1]) begin
			r = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

@@ rtl/core/pis_error_stage.sv @@
// Input register, error, separated integral and derivative for the PID core.
// Holds the controller state (integral and previous error). Uses pis_pkg.
module pis_error_stage (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load_s1,
	input  logic                                  load_s2,
	input  logic signed [pis_pkg::SAMPLE_WIDTH-1:0] target_value,
	input  logic signed [pis_pkg::SAMPLE_WIDTH-1:0] measured_value,
	input  logic        [pis_pkg::LIMIT_WIDTH-1:0]  separation_limit,
	output logic signed [pis_pkg::ERR_WIDTH-1:0]    err_s2,
	output logic signed [pis_pkg::SUM_WIDTH-1:0]    sum_s2,
	output logic signed [pis_pkg::DERIV_WIDTH-1:0]  deriv_s2
);

	logic signed [pis_pkg::SAMPLE_WIDTH-1:0] target_s1;
	logic signed [pis_pkg::SAMPLE_WIDTH-1:0] measured_s1;
	logic signed [pis_pkg::SUM_WIDTH-1:0]    error_sum_q;
	logic signed [pis_pkg::ERR_WIDTH-1:0]    last_error_q;

	logic signed [pis_pkg::ERR_WIDTH-1:0]    err;
	logic        [pis_pkg::ERR_WIDTH-1:0]    mag;
	logic                                    in_band;
	logic signed [pis_pkg::SUM_WIDTH:0]      sum_ext;
	logic signed [pis_pkg::SUM_WIDTH-1:0]    sum_sat;
	logic signed [pis_pkg::SUM_WIDTH-1:0]    sum_next;
	logic signed [pis_pkg::DERIV_WIDTH-1:0]  deriv;

	always_comb begin
		err = {target_s1[pis_pkg::SAMPLE_WIDTH-1], target_s1}
			- {measured_s1[pis_pkg::SAMPLE_WIDTH-1], measured_s1};
		mag = err[pis_pkg::ERR_WIDTH-1] ? (~err + pis_pkg::ERR_WIDTH'(1)) : err;
		in_band = mag < {1'b0, separation_limit};
		sum_ext = {error_sum_q[pis_pkg::SUM_WIDTH-1], error_sum_q}
			+ {{(pis_pkg::SUM_WIDTH+1-pis_pkg::ERR_WIDTH){err[pis_pkg::ERR_WIDTH-1]}}, err};
		// two top bits differ: the add left the 32-bit range
		if (sum_ext[pis_pkg::SUM_WIDTH] == sum_ext[pis_pkg::SUM_WIDTH-1]) begin
			sum_sat = sum_ext[pis_pkg::SUM_WIDTH-1:0];
		end else if (sum_ext[pis_pkg::SUM_WIDTH]) begin
			sum_sat = {1'b1, {(pis_pkg::SUM_WIDTH-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(pis_pkg::SUM_WIDTH-1){1'b1}}};
		end
		sum_next = in_band ? sum_sat : error_sum_q;
		deriv = {err[pis_pkg::ERR_WIDTH-1], err}
			- {last_error_q[pis_pkg::ERR_WIDTH-1], last_error_q};
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			target_s1   <= target_value;
			measured_s1 <= measured_value;
		end
		if (load_s2) begin
			err_s2   <= err;
			sum_s2   <= sum_next;
			deriv_s2 <= deriv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (load_s2) begin
			error_sum_q  <= sum_next;
			last_error_q <= err;
		end
	end

endmodule

@@ rtl/core/pis_product_stage.sv @@
// Gain multipliers of the PID core: one registered product per term.
// Uses pis_pkg.
module pis_product_stage (
	input  logic                                  clk,
	input  logic                                  load_s3,
	input  logic signed [pis_pkg::GAIN_WIDTH-1:0]   kp_gain,
	input  logic signed [pis_pkg::GAIN_WIDTH-1:0]   ki_gain,
	input  logic signed [pis_pkg::GAIN_WIDTH-1:0]   kd_gain,
	input  logic signed [pis_pkg::ERR_WIDTH-1:0]    err_s2,
	input  logic signed [pis_pkg::SUM_WIDTH-1:0]    sum_s2,
	input  logic signed [pis_pkg::DERIV_WIDTH-1:0]  deriv_s2,
	output logic signed [pis_pkg::P_KP_WIDTH-1:0]   p_kp_s3,
	output logic signed [pis_pkg::P_KI_WIDTH-1:0]   p_ki_s3,
	output logic signed [pis_pkg::P_KD_WIDTH-1:0]   p_kd_s3
);

	logic signed [pis_pkg::P_KP_WIDTH-1:0] p_kp;
	logic signed [pis_pkg::P_KI_WIDTH-1:0] p_ki;
	logic signed [pis_pkg::P_KD_WIDTH-1:0] p_kd;

	assign p_kp = kp_gain * err_s2;
	assign p_ki = ki_gain * sum_s2;
	assign p_kd = kd_gain * deriv_s2;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			p_kp_s3 <= p_kp;
			p_ki_s3 <= p_ki;
			p_kd_s3 <= p_kd;
		end
	end

endmodule

@@ rtl/core/pis_sum_stage.sv @@
// Sum of the three PID terms, floor shift by the gain fraction and output
// saturation into the output register. Uses pis_pkg.
module pis_sum_stage (
	input  logic                                  clk,
	input  logic                                  load_s4,
	input  logic signed [pis_pkg::P_KP_WIDTH-1:0]   p_kp_s3,
	input  logic signed [pis_pkg::P_KI_WIDTH-1:0]   p_ki_s3,
	input  logic signed [pis_pkg::P_KD_WIDTH-1:0]   p_kd_s3,
	output logic signed [pis_pkg::DRIVE_WIDTH-1:0]  drive_s4
);

	logic signed [pis_pkg::ACC_WIDTH-1:0] acc;
	logic signed [pis_pkg::ACC_WIDTH-1:0] acc_shift;

	always_comb begin
		acc = pis_pkg::ACC_WIDTH'(p_kp_s3) + pis_pkg::ACC_WIDTH'(p_ki_s3)
			+ pis_pkg::ACC_WIDTH'(p_kd_s3);
		// arithmetic shift rounds toward minus infinity
		acc_shift = acc >>> pis_pkg::GAIN_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			drive_s4 <= pis_pkg::sat_drive(acc_shift);
		end
	end

endmodule

@@ rtl/core/pid_integral_separation.sv @@
// PID controller with integral separation, four-stage pipeline.
// A word passes the input register (stage 1), the error stage (stage 2), the
// products (stage 3) and the sum stage, which loads the output register (stage 4).
// Throughput: one word per cycle while drive_stall is low; each stage moves on when the next has room.
// Reset (arst_n, asynchronous): pipeline empty, integral and previous error
// zero, gains zero, separation limit 400.
module pid_integral_separation (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write_en,
	input  logic [pis_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
	input  logic [pis_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  logic signed [pis_pkg::SAMPLE_WIDTH-1:0] target_value,
	input  logic signed [pis_pkg::SAMPLE_WIDTH-1:0] measured_value,
	output logic                                    drive_valid,
	input  logic                                    drive_stall,
	output logic signed [pis_pkg::DRIVE_WIDTH-1:0]  drive_value
);

	// configuration registers
	logic signed [pis_pkg::GAIN_WIDTH-1:0]  kp_gain_q;
	logic signed [pis_pkg::GAIN_WIDTH-1:0]  ki_gain_q;
	logic signed [pis_pkg::GAIN_WIDTH-1:0]  kd_gain_q;
	logic        [pis_pkg::LIMIT_WIDTH-1:0] separation_limit_q;

	// stage valids and moves
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic room_s1, room_s2, room_s3, room_s4;
	logic load_s1, load_s2, load_s3, load_s4;

	// stage payload
	logic signed [pis_pkg::ERR_WIDTH-1:0]   err_s2;
	logic signed [pis_pkg::SUM_WIDTH-1:0]   sum_s2;
	logic signed [pis_pkg::DERIV_WIDTH-1:0] deriv_s2;
	logic signed [pis_pkg::P_KP_WIDTH-1:0]  p_kp_s3;
	logic signed [pis_pkg::P_KI_WIDTH-1:0]  p_ki_s3;
	logic signed [pis_pkg::P_KD_WIDTH-1:0]  p_kd_s3;

	// Register writes: the user must change these only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_gain_q          <= '0;
			ki_gain_q          <= '0;
			kd_gain_q          <= '0;
			separation_limit_q <= pis_pkg::SEP_RESET;
		end else if (cfg_write_en) begin
			case (pis_pkg::cfg_reg_t'(cfg_index))
				pis_pkg::REG_KP:  kp_gain_q          <= cfg_data;
				pis_pkg::REG_KI:  ki_gain_q          <= cfg_data;
				pis_pkg::REG_KD:  kd_gain_q          <= cfg_data;
				pis_pkg::REG_SEP: separation_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage has room when it is empty or its word moves on this cycle;
	// bubbles collapse so a stalled output only holds what is behind it.
	always_comb begin
		room_s4 = !valid_s4 || !drive_stall;
		room_s3 = !valid_s3 || room_s4;
		room_s2 = !valid_s2 || room_s3;
		room_s1 = !valid_s1 || room_s2;
		load_s1 = sample_valid && room_s1;
		load_s2 = valid_s1 && room_s2;
		load_s3 = valid_s2 && room_s3;
		load_s4 = valid_s3 && room_s4;
	end

	assign sample_stall = !room_s1;
	assign drive_valid  = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (room_s1) valid_s1 <= sample_valid;
			if (room_s2) valid_s2 <= valid_s1;
			if (room_s3) valid_s3 <= valid_s2;
			if (room_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1 holds the input word; stage 2 forms the error and updates the
	// integral and previous error, so consecutive words see each other's state.
	pis_error_stage u_error (
		.clk              (clk),
		.arst_n           (arst_n),
		.load_s1          (load_s1),
		.load_s2          (load_s2),
		.target_value     (target_value),
		.measured_value   (measured_value),
		.separation_limit (separation_limit_q),
		.err_s2           (err_s2),
		.sum_s2           (sum_s2),
		.deriv_s2         (deriv_s2)
	);

	// Stage 3: one multiplier per term.
	pis_product_stage u_product (
		.clk      (clk),
		.load_s3  (load_s3),
		.kp_gain  (kp_gain_q),
		.ki_gain  (ki_gain_q),
		.kd_gain  (kd_gain_q),
		.err_s2   (err_s2),
		.sum_s2   (sum_s2),
		.deriv_s2 (deriv_s2),
		.p_kp_s3  (p_kp_s3),
		.p_ki_s3  (p_ki_s3),
		.p_kd_s3  (p_kd_s3)
	);

	// Stage 4: add, drop the fraction bits, saturate into the output register.
	pis_sum_stage u_sum (
		.clk      (clk),
		.load_s4  (load_s4),
		.p_kp_s3  (p_kp_s3),
		.p_ki_s3  (p_ki_s3),
		.p_kd_s3  (p_kd_s3),
		.drive_s4 (drive_value)
	);

endmodule
